### rtl/rts_pkg.sv
// Shared types and constants for the region timing statistics table.
// Holds command/status codes, the table entry layout and the control states.
// No dependencies.
package rts_pkg;

    localparam int REGIONS  = 64;
    localparam int AW       = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int TW       = 63;
    localparam int CW       = 32;
    localparam int RIDW     = 6;
    localparam int CMDW     = 2;
    localparam int STW      = 3;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 416;

    localparam logic [TW-1:0] ALL_ONES = {TW{1'b1}};
    localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};

    // command codes
    localparam logic [CMDW-1:0] CMD_BEGIN = 2'd0;
    localparam logic [CMDW-1:0] CMD_END   = 2'd1;
    localparam logic [CMDW-1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [STW-1:0] ST_OK          = 3'd0;
    localparam logic [STW-1:0] ST_DBL_BEGIN   = 3'd1;
    localparam logic [STW-1:0] ST_DBL_END     = 3'd2;
    localparam logic [STW-1:0] ST_UNUSED      = 3'd3;
    localparam logic [STW-1:0] ST_END_IGNORED = 3'd4;

    typedef struct packed {
        logic [TW-1:0] acc;
        logic [CW-1:0] cnt;
        logic [TW-1:0] lo0;
        logic [TW-1:0] lo1;
        logic [TW-1:0] hi0;
        logic [TW-1:0] hi1;
    } stats_t;

    typedef struct packed {
        logic [TW-1:0] stamp;
        stats_t        stats;
    } entry_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_UPD  = 6'b000100,
        S_SCAN = 6'b001000,
        S_DONE = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    function automatic stats_t init_stats();
        stats_t s;
        s.acc = '0;
        s.cnt = '0;
        s.lo0 = ALL_ONES;
        s.lo1 = ALL_ONES;
        s.hi0 = '0;
        s.hi1 = '0;
        return s;
    endfunction

endpackage

### rtl/region_timing_statistics_table.sv
// Top level of the region timing statistics table.
// Uses rts_pkg for codes, entry layout and states.
//
// Each input word is a begin, end or clear command for one region; exactly one
// result word comes back per input. Per-region start stamp and statistics live in
// one single-port-read table memory, read-modified-written per item. An item steps
// through accept, table read, update/write back and result; a successful end also
// walks the table one entry a cycle to find the minimum call count over used
// regions. Clear takes one pass of flag flops, not a memory sweep. A new word is
// accepted while the previous result still waits on the output register.
module region_timing_statistics_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // command[1:0], region_id[7:2], timestamp[70:8], zero pad
    input  logic [rts_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status[2:0], elapsed[65:3], total_time[128:66], call_count[160:129],
    // smallest[223:161], second_smallest[286:224], largest[349:287],
    // second_largest[412:350], round_complete[413], zero pad
    output logic [rts_pkg::OUT_W-1:0]   m_tdata
);

    rts_pkg::state_t state_reg, state_next;

    logic [rts_pkg::REGIONS-1:0] used_reg, running_reg, sv_reg;

    // table memory
    rts_pkg::entry_t mem [rts_pkg::REGIONS];
    rts_pkg::entry_t rd_data;
    logic [rts_pkg::AW-1:0] rd_addr;
    logic                   wr_en;
    rts_pkg::entry_t        wr_data;

    // item registers
    logic [rts_pkg::CMDW-1:0] cmd_reg;
    logic [rts_pkg::RIDW-1:0] rid_reg;
    logic [rts_pkg::TW-1:0]   ts_reg;
    logic [rts_pkg::AW-1:0]   addr_reg;
    rts_pkg::entry_t          ent_reg;
    logic [rts_pkg::TW-1:0]   el_reg;

    // staged result
    logic [rts_pkg::STW-1:0]  st_reg;
    logic [rts_pkg::TW-1:0]   rel_reg;
    rts_pkg::stats_t          rstat_reg;

    // scan
    logic [rts_pkg::AW:0]     scan_reg;
    logic                     chk_vld_reg;
    logic [rts_pkg::AW-1:0]   chk_idx_reg;
    logic [rts_pkg::CW-1:0]   min_reg;

    logic                     m_valid_reg;
    logic [rts_pkg::OUT_W-1:0] m_data_reg;

    logic accept;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == rts_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // read address: scan pointer while scanning, else the incoming region
    always_comb begin
        if (state_reg == rts_pkg::S_SCAN) begin
            rd_addr = scan_reg[rts_pkg::AW-1:0];
        end else begin
            rd_addr = rts_pkg::AW'(s_tdata[7:2]);
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
        if (wr_en) begin
            mem[addr_reg] <= wr_data;
        end
    end

    // update stage decode
    logic            valid_c, used_c, run_c;
    logic [63:0]     sum_c;
    rts_pkg::stats_t new_c, show_c;
    logic [rts_pkg::STW-1:0] st_c;
    logic            good_end_c;

    always_comb begin
        valid_c = (32'(rid_reg) < 32'(rts_pkg::REGIONS));
        used_c  = valid_c && used_reg[addr_reg];
        run_c   = used_c && running_reg[addr_reg];

        // successful end statistics
        sum_c = {1'b0, ent_reg.stats.acc} + {1'b0, el_reg};
        new_c = ent_reg.stats;
        new_c.acc = sum_c[63] ? rts_pkg::ALL_ONES : sum_c[rts_pkg::TW-1:0];
        if (ent_reg.stats.cnt != rts_pkg::CNT_MAX) begin
            new_c.cnt = ent_reg.stats.cnt + 1'b1;
        end
        if (el_reg < ent_reg.stats.lo0) begin
            new_c.lo1 = ent_reg.stats.lo0;
            new_c.lo0 = el_reg;
        end else if (el_reg < ent_reg.stats.lo1) begin
            new_c.lo1 = el_reg;
        end
        if (el_reg > ent_reg.stats.hi0) begin
            new_c.hi1 = ent_reg.stats.hi0;
            new_c.hi0 = el_reg;
        end else if (el_reg > ent_reg.stats.hi1) begin
            new_c.hi1 = el_reg;
        end

        st_c       = rts_pkg::ST_OK;
        good_end_c = 1'b0;
        wr_en      = 1'b0;
        wr_data    = ent_reg;
        case (cmd_reg)
            rts_pkg::CMD_BEGIN: begin
                if (!valid_c) begin
                    st_c = rts_pkg::ST_UNUSED;
                end else if (!used_c) begin
                    wr_en         = (state_reg == rts_pkg::S_UPD);
                    wr_data.stamp = ts_reg;
                    wr_data.stats = rts_pkg::init_stats();
                end else if (run_c) begin
                    st_c = rts_pkg::ST_DBL_BEGIN;
                end else begin
                    wr_en         = (state_reg == rts_pkg::S_UPD);
                    wr_data.stamp = ts_reg;
                end
            end
            rts_pkg::CMD_END: begin
                if (!used_c) begin
                    st_c = rts_pkg::ST_UNUSED;
                end else if (!run_c) begin
                    st_c = (ent_reg.stamp == '0) ? rts_pkg::ST_DBL_END
                                                 : rts_pkg::ST_END_IGNORED;
                end else begin
                    good_end_c    = 1'b1;
                    wr_en         = (state_reg == rts_pkg::S_UPD);
                    wr_data.stamp = '0;
                    wr_data.stats = new_c;
                end
            end
            default: begin
            end
        endcase

        // statistics shown in the result
        if (cmd_reg == rts_pkg::CMD_CLEAR || !used_c) begin
            show_c = rts_pkg::init_stats();
        end else if (good_end_c) begin
            show_c = new_c;
        end else begin
            show_c = ent_reg.stats;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rts_pkg::S_IDLE: if (accept) state_next = rts_pkg::S_READ;
            rts_pkg::S_READ: state_next = rts_pkg::S_UPD;
            rts_pkg::S_UPD: begin
                state_next = good_end_c ? rts_pkg::S_SCAN : rts_pkg::S_DONE;
            end
            rts_pkg::S_SCAN: begin
                if (scan_reg == (rts_pkg::AW+1)'(rts_pkg::REGIONS) && !chk_vld_reg) begin
                    state_next = rts_pkg::S_DONE;
                end
            end
            rts_pkg::S_DONE: begin
                if (!m_valid_reg || m_tready) state_next = rts_pkg::S_IDLE;
            end
            default: state_next = rts_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rts_pkg::S_IDLE;
            used_reg    <= '0;
            running_reg <= '0;
            sv_reg      <= '0;
            m_valid_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // output valid: load a finished result, else drop a taken one
            if (state_reg == rts_pkg::S_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == rts_pkg::S_UPD) begin
                if (cmd_reg == rts_pkg::CMD_CLEAR) begin
                    running_reg <= '0;
                    sv_reg      <= '0;
                end else if (wr_en) begin
                    used_reg[addr_reg]    <= 1'b1;
                    sv_reg[addr_reg]      <= 1'b1;
                    running_reg[addr_reg] <= !good_end_c;
                end
            end
            if (state_reg == rts_pkg::S_SCAN) begin
                chk_vld_reg <= (scan_reg != (rts_pkg::AW+1)'(rts_pkg::REGIONS));
            end else begin
                chk_vld_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_tdata[1:0];
            rid_reg  <= s_tdata[7:2];
            ts_reg   <= s_tdata[70:8];
            addr_reg <= rts_pkg::AW'(s_tdata[7:2]);
        end
        if (state_reg == rts_pkg::S_READ) begin
            ent_reg.stamp <= rd_data.stamp;
            ent_reg.stats <= sv_reg[addr_reg] ? rd_data.stats : rts_pkg::init_stats();
            el_reg        <= ts_reg - rd_data.stamp;
        end
        if (state_reg == rts_pkg::S_UPD) begin
            st_reg    <= st_c;
            rel_reg   <= good_end_c ? el_reg : '0;
            rstat_reg <= show_c;
            scan_reg  <= '0;
            min_reg   <= rts_pkg::CNT_MAX;
        end
        if (state_reg == rts_pkg::S_SCAN) begin
            if (scan_reg != (rts_pkg::AW+1)'(rts_pkg::REGIONS)) begin
                scan_reg <= scan_reg + 1'b1;
            end
            chk_idx_reg <= scan_reg[rts_pkg::AW-1:0];
            // other used regions; the addressed one is compared at the end
            if (chk_vld_reg && used_reg[chk_idx_reg] && chk_idx_reg != addr_reg) begin
                if (!sv_reg[chk_idx_reg]) begin
                    min_reg <= '0;
                end else if (rd_data.stats.cnt < min_reg) begin
                    min_reg <= rd_data.stats.cnt;
                end
            end
        end
        if (state_reg == rts_pkg::S_DONE && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {2'b00,
                           (st_reg == rts_pkg::ST_OK && rel_reg != '0 ||
                            st_reg == rts_pkg::ST_OK && cmd_reg == rts_pkg::CMD_END)
                               && cmd_reg == rts_pkg::CMD_END
                               && rstat_reg.cnt <= min_reg,
                           rstat_reg.hi1, rstat_reg.hi0, rstat_reg.lo1, rstat_reg.lo0,
                           rstat_reg.cnt, rstat_reg.acc, rel_reg, st_reg};
        end
    end

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == rts_pkg::S_READ)
        else $error("accepted word did not start a table read");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rts_pkg::S_SCAN |-> scan_reg <= (rts_pkg::AW+1)'(rts_pkg::REGIONS))
        else $error("scan pointer ran past the table");
    a_result_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rts_pkg::S_DONE && (!m_valid_reg || m_tready) |=> m_valid_reg)
        else $error("result not presented after completion");
    a_round_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[413] |-> m_data_reg[2:0] == rts_pkg::ST_OK)
        else $error("round flag on a failed command");
`endif

endmodule
